FILE: rtl/sm3_hash_engine_assert.svh
// assertion macros for the sm3 hash engine
`ifndef SM3_HASH_ENGINE_ASSERT_SVH
`define SM3_HASH_ENGINE_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define SM3_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define SM3_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/sm3_pkg.sv
// shared types, constants and functions of the sm3 hash engine
`timescale 1ns / 1ps

package sm3_pkg;

    typedef logic [31:0] word_t;

    // word k of the chaining value sits at index 7-k (a at index 7)
    typedef logic [7:0][31:0] chain_t;

    // expansion window, index 0 holds the oldest word
    typedef logic [15:0][31:0] window_t;

    localparam chain_t SM3_IV = {
        32'h7380166F, 32'h4914B2B9, 32'h172442D7, 32'hDA8A0600,
        32'hA96F30BC, 32'h163138AA, 32'hE38DEE4D, 32'hB0FB0E4E
    };

    localparam word_t SM3_T_LOW  = 32'h79CC4519;
    localparam word_t SM3_T_HIGH = 32'h7A879D8A;
    localparam word_t SM3_PAD_WORD = 32'h80000000;

    function automatic word_t rotl32(input word_t x, input logic [4:0] n);
        logic [63:0] both;
        both = {x, x} << n;
        return both[63:32];
    endfunction

    function automatic word_t perm0(input word_t x);
        return x ^ rotl32(x, 5'd9) ^ rotl32(x, 5'd17);
    endfunction

    function automatic word_t perm1(input word_t x);
        return x ^ rotl32(x, 5'd15) ^ rotl32(x, 5'd23);
    endfunction

endpackage

FILE: rtl/sm3_round.sv
// one sm3 compression round and one message expansion step
`timescale 1ns / 1ps

module sm3_round (
    input  sm3_pkg::chain_t  state_in,
    input  sm3_pkg::window_t window,
    input  logic [5:0]       round_idx,
    output sm3_pkg::chain_t  state_out,
    output sm3_pkg::word_t   expand_word
);
    import sm3_pkg::*;

    word_t a, b, c, d, e, f, g, h;
    word_t tj, a12, ss1, ss2, ff, gg, tt1, tt2, wj, wpj;
    logic  low_rounds;

    assign a = state_in[7];
    assign b = state_in[6];
    assign c = state_in[5];
    assign d = state_in[4];
    assign e = state_in[3];
    assign f = state_in[2];
    assign g = state_in[1];
    assign h = state_in[0];

    assign low_rounds = (round_idx[5:4] == 2'b00);
    assign wj  = window[0];
    assign wpj = window[0] ^ window[4];

    always_comb begin
        tj  = low_rounds ? SM3_T_LOW : SM3_T_HIGH;
        a12 = rotl32(a, 5'd12);
        ss1 = rotl32(a12 + e + rotl32(tj, round_idx[4:0]), 5'd7);
        ss2 = ss1 ^ a12;
        if (low_rounds) begin
            ff = a ^ b ^ c;
            gg = e ^ f ^ g;
        end else begin
            ff = (a & b) | (a & c) | (b & c);
            gg = (e & f) | (~e & g);
        end
        tt1 = ff + d + ss2 + wpj;
        tt2 = gg + h + ss1 + wj;
        state_out = {tt1, a, rotl32(b, 5'd9), c, perm0(tt2), e, rotl32(f, 5'd19), g};
    end

    assign expand_word = perm1(window[0] ^ window[7] ^ rotl32(window[13], 5'd15))
                       ^ rotl32(window[3], 5'd7) ^ window[10];

endmodule

FILE: rtl/sm3_hash_engine.sv
// sm3 hash engine: word buffer, padding sequencer and iterative compression
// a message word is absorbed while idle; every 16th buffered word starts a
// compression, one round per cycle through the single shared round unit;
// new words wait until the compression is done; the final word is followed by
// padding words one per cycle between compressions, one or two compressions and
// 8 digest transactions; reset loads the initial vector and clears the counters
`timescale 1ns / 1ps

module sm3_hash_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sm3_pkg::word_t       s_message_word,
    input  logic [2:0]           s_valid_bytes,
    input  logic                 s_final_word,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sm3_pkg::word_t       m_digest_word,
    output logic [2:0]           m_word_position,
    output logic                 m_last_word
);
    import sm3_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FILL,
        ST_COMP,
        ST_OUT
    } state_t;

    state_t       state_reg, state_next;
    chain_t       chain_reg, chain_next;
    logic [3:0]   idx_reg, idx_next;
    logic [60:0]  count_reg, count_next;
    logic         fin_reg, fin_next;
    logic         pad_pend_reg, pad_pend_next;
    logic         len_hi_reg, len_hi_next;
    logic [2:0]   pos_reg, pos_next;
    logic [5:0]   round_reg, round_next;

    window_t      win_reg, win_next;
    chain_t       work_reg, work_next;

    chain_t       round_out;
    word_t        expand_word;
    logic         push;
    word_t        push_word;
    logic [2:0]   vb_sat;

    sm3_round u_round (
        .state_in    (work_reg),
        .window      (win_reg),
        .round_idx   (round_reg),
        .state_out   (round_out),
        .expand_word (expand_word)
    );

    assign vb_sat = (s_valid_bytes > 3'd4) ? 3'd4 : s_valid_bytes;

    always_comb begin
        state_next    = state_reg;
        chain_next    = chain_reg;
        idx_next      = idx_reg;
        count_next    = count_reg;
        fin_next      = fin_reg;
        pad_pend_next = pad_pend_reg;
        len_hi_next   = len_hi_reg;
        pos_next      = pos_reg;
        round_next    = round_reg;
        win_next      = win_reg;
        work_next     = work_reg;
        push          = 1'b0;
        push_word     = '0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    push = 1'b1;
                    if (!s_final_word) begin
                        push_word  = s_message_word;
                        count_next = count_reg + 61'd4;
                    end else begin
                        fin_next      = 1'b1;
                        len_hi_next   = 1'b0;
                        count_next    = count_reg + {58'd0, vb_sat};
                        pad_pend_next = (vb_sat == 3'd4);
                        case (vb_sat)
                            3'd0:    push_word = SM3_PAD_WORD;
                            3'd1:    push_word = {s_message_word[31:24], 24'h800000};
                            3'd2:    push_word = {s_message_word[31:16], 16'h8000};
                            3'd3:    push_word = {s_message_word[31:8], 8'h80};
                            default: push_word = s_message_word;
                        endcase
                    end
                end
            end
            ST_FILL: begin
                push = 1'b1;
                if (pad_pend_reg) begin
                    push_word     = SM3_PAD_WORD;
                    pad_pend_next = 1'b0;
                end else if (len_hi_reg) begin
                    push_word = {count_reg[28:0], 3'b000};
                end else if (idx_reg == 4'd14) begin
                    push_word   = count_reg[60:29];
                    len_hi_next = 1'b1;
                end else begin
                    push_word = '0;
                end
            end
            ST_COMP: begin
                work_next  = round_out;
                round_next = round_reg + 6'd1;
                win_next   = {expand_word, win_reg[15:1]};
                if (round_reg == 6'd63) begin
                    chain_next = chain_reg ^ round_out;
                    if (fin_reg && len_hi_reg) begin
                        state_next = ST_OUT;
                        pos_next   = '0;
                    end else if (fin_reg) begin
                        state_next = ST_FILL;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (m_ready) begin
                    pos_next = pos_reg + 3'd1;
                    if (pos_reg == 3'd7) begin
                        state_next  = ST_IDLE;
                        chain_next  = SM3_IV;
                        idx_next    = '0;
                        count_next  = '0;
                        fin_next    = 1'b0;
                        len_hi_next = 1'b0;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase

        if (push) begin
            win_next = {push_word, win_reg[15:1]};
            idx_next = idx_reg + 4'd1;
            if (idx_reg == 4'd15) begin
                state_next = ST_COMP;
                work_next  = chain_reg;
                round_next = '0;
            end else if (fin_next) begin
                state_next = ST_FILL;
            end else begin
                state_next = ST_IDLE;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            chain_reg    <= SM3_IV;
            idx_reg      <= '0;
            count_reg    <= '0;
            fin_reg      <= 1'b0;
            pad_pend_reg <= 1'b0;
            len_hi_reg   <= 1'b0;
            pos_reg      <= '0;
            round_reg    <= '0;
        end else begin
            state_reg    <= state_next;
            chain_reg    <= chain_next;
            idx_reg      <= idx_next;
            count_reg    <= count_next;
            fin_reg      <= fin_next;
            pad_pend_reg <= pad_pend_next;
            len_hi_reg   <= len_hi_next;
            pos_reg      <= pos_next;
            round_reg    <= round_next;
        end
    end

    always_ff @(posedge aclk) begin
        win_reg  <= win_next;
        work_reg <= work_next;
    end

    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = (state_reg == ST_OUT);
    assign m_digest_word   = chain_reg[3'd7 - pos_reg];
    assign m_word_position = pos_reg;
    assign m_last_word     = (pos_reg == 3'd7);

    `include "sm3_hash_engine_assert.svh"

    // no input is taken while the digest is being delivered
    `SM3_ASSERT_SAME(a_ready_excl, m_valid, !s_ready, "input ready during digest output")

    // the last digest transaction restarts the message
    `SM3_ASSERT_NEXT(a_restart, m_valid && m_ready && m_last_word,
        s_ready && idx_reg == 4'd0 && count_reg == 61'd0, "engine not restarted after digest")

    // digest words come out in order
    `SM3_ASSERT_NEXT(a_pos_step, m_valid && m_ready && !m_last_word,
        m_valid && m_word_position == $past(m_word_position) + 3'd1, "digest word skipped")

    // a compression starts only with a full block
    `SM3_ASSERT_NEXT(a_comp_start, state_reg != ST_COMP && state_next == ST_COMP,
        idx_reg == 4'd0 && round_reg == 6'd0, "compression started on partial block")

endmodule
